// ===== rtl/byte_level_alphabet_decoder_assert.svh =====
// Assertion macros for the byte-level alphabet decoder RTL.
`ifndef BYTE_LEVEL_ALPHABET_DECODER_ASSERT_SVH
`define BYTE_LEVEL_ALPHABET_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BLADEC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLADEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BLADEC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define BLADEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/bladec_pkg.sv =====
// Package with item types, decoder state type and status codes.
`timescale 1ns / 1ps

package bladec_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_TRUNC = 2'd1;
  localparam logic [1:0] STATUS_UNSUP = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [20:0] code_accum;
    logic [1:0]  bytes_left;
    logic        discarding;
  } dec_state_t;

  typedef struct packed {
    logic      emit;
    out_item_t result;
  } step_out_t;

endpackage

// ===== rtl/byte_level_alphabet_decoder.sv =====
// Top level of the byte-level alphabet decoder: UTF-8 bytes in, raw bytes out.
//
//   Channel   Handshake                Payload     Moves
//   byte      byte_valid / byte_stall  byte_item   one UTF-8 byte per item
//   res       res_valid / res_stall    res_item    one decoded byte or error
//
// One byte is accepted every cycle unless the input stalls; the last byte of a
// result waits in the input register and is decoded into the result register
// when the input register hands it on.
// Reset clears the valid flags and the sequence state.
// The input stalls only when a byte that gives a result meets a full,
// stalled result register; bytes that give no result keep flowing.
`timescale 1ns / 1ps

`include "byte_level_alphabet_decoder_assert.svh"

module byte_level_alphabet_decoder import bladec_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic       s1_valid;
  in_item_t   s1_item;
  dec_state_t state;
  dec_state_t state_next;
  step_out_t  step;
  logic       out_free;
  logic       s1_take;

  bladec_step u_step (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .step       (step)
  );

  assign out_free   = !res_valid || !res_stall;
  assign s1_take    = s1_valid && (!step.emit || out_free);
  assign byte_stall = s1_valid && !s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      state     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (!s1_valid || s1_take) begin
        s1_valid <= byte_valid;
      end
      if (s1_take) begin
        state <= state_next;
      end
      if (s1_take && step.emit) begin
        res_valid <= 1'b1;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
    if (s1_take && step.emit) begin
      res_item <= step.result;
    end
  end

  `BLADEC_ASSERT_SAME(a_error_result, clk, rst,
    res_valid && (res_item.status != STATUS_OK),
    (res_item.out_byte == 8'd0) && res_item.last, "error result must be zero and last")
  `BLADEC_ASSERT_NEXT(a_eos_idle, clk, rst, s1_take && s1_item.end_of_string,
    state == '0, "decoder not idle after end of string")
  `BLADEC_ASSERT_SAME(a_no_discard_mid_seq, clk, rst, state.bytes_left != 2'd0,
    !state.discarding, "discarding while inside a sequence")
  `BLADEC_ASSERT_SAME(a_stall_cause, clk, rst, byte_stall,
    res_valid && res_stall, "input stalled without a blocked result")

endmodule

// ===== rtl/bladec_step.sv =====
// One decoding step: next decoder state and optional result for one byte.
`timescale 1ns / 1ps

module bladec_step import bladec_pkg::*; (
  input  dec_state_t state,
  input  in_item_t   item,
  output dec_state_t state_next,
  output step_out_t  step
);

  logic [20:0] accum_shift;
  logic [1:0]  left_dec;
  logic [20:0] cp;
  logic [7:0]  low;
  logic        in_base;
  logic        in_shift;
  logic [6:0]  k;
  logic        mapped;
  logic [7:0]  raw;

  assign accum_shift = {state.code_accum[14:0], item.in_byte[5:0]};
  assign left_dec    = state.bytes_left - 2'd1;
  assign cp          = (state.bytes_left == 2'd0) ? {13'd0, item.in_byte} : accum_shift;

  // Map the code point back to its raw byte.
  assign low      = cp[7:0];
  assign in_base  = (cp[20:8] == 13'd0) &&
                    (((low >= 8'd33) && (low <= 8'd126)) ||
                     ((low >= 8'd161) && (low <= 8'd172)) ||
                     (low >= 8'd174));
  assign in_shift = (cp[20:8] == 13'd1) && (low <= 8'd67);
  assign k        = low[6:0];
  assign mapped   = in_base || in_shift;

  always_comb begin
    if (in_base) begin
      raw = low;
    end else if (k < 7'd33) begin
      raw = {1'b0, k};
    end else if (k < 7'd67) begin
      raw = {1'b0, k} + 8'd94;
    end else begin
      raw = 8'd173;
    end
  end

  always_comb begin
    state_next  = state;
    step.emit   = 1'b0;
    step.result = '0;
    if (state.discarding) begin
      if (item.end_of_string) begin
        state_next = '0;
      end
    end else if ((state.bytes_left == 2'd0) && (item.in_byte >= 8'd192)) begin
      priority if (item.in_byte >= 8'd240) begin
        state_next.code_accum = {18'd0, item.in_byte[2:0]};
        state_next.bytes_left = 2'd3;
      end else if (item.in_byte >= 8'd224) begin
        state_next.code_accum = {17'd0, item.in_byte[3:0]};
        state_next.bytes_left = 2'd2;
      end else begin
        state_next.code_accum = {16'd0, item.in_byte[4:0]};
        state_next.bytes_left = 2'd1;
      end
      if (item.end_of_string) begin
        state_next         = '0;
        step.emit          = 1'b1;
        step.result.status = STATUS_TRUNC;
        step.result.last   = 1'b1;
      end
    end else if ((state.bytes_left != 2'd0) && (left_dec != 2'd0)) begin
      state_next.code_accum = accum_shift;
      state_next.bytes_left = left_dec;
      if (item.end_of_string) begin
        state_next         = '0;
        step.emit          = 1'b1;
        step.result.status = STATUS_TRUNC;
        step.result.last   = 1'b1;
      end
    end else begin
      // A complete code point is ready.
      state_next = '0;
      step.emit  = 1'b1;
      if (mapped) begin
        step.result.out_byte = raw;
        step.result.status   = STATUS_OK;
        step.result.last     = item.end_of_string;
      end else begin
        state_next.discarding = !item.end_of_string;
        step.result.status    = STATUS_UNSUP;
        step.result.last      = 1'b1;
      end
    end
  end

endmodule

// ===== tb/tb_byte_level_alphabet_decoder.sv =====
// Testbench for the byte-level alphabet decoder: directed table, random strings, self-check.
`timescale 1ns / 1ps

module tb_byte_level_alphabet_decoder import bladec_pkg::*; ();

  typedef struct packed {
    logic      given;
    logic      has_res;
    out_item_t res;
  } byte_note_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       given;
    logic       has_res;
    logic [7:0] exp_byte;
    logic [1:0] exp_status;
    logic       exp_last;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int decoded_cnt = 0;

  byte_note_t byte_notes[$];
  out_item_t  decoded_q[$];

  logic [20:0] dec_acc = '0;
  logic [1:0]  dec_left = '0;
  logic        dec_drop = 1'b0;

  byte_note_t cur_note;
  out_item_t  pred_res;
  out_item_t  want;
  logic       got_res;

  dir_row_t dir_rows [26];

  byte_level_alphabet_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic map_code_point(input logic [20:0] cp, output logic [7:0] raw);
    raw = '0;
    if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) || (cp >= 174 && cp <= 255)) begin
      raw = cp[7:0];
      return 1'b1;
    end
    if (cp >= 256 && cp <= 323) begin
      if (cp < 289) begin
        raw = 8'(cp - 21'd256);
      end else if (cp < 323) begin
        raw = 8'(cp - 21'd162);
      end else begin
        raw = 8'd173;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic decode_byte(input in_item_t it, output out_item_t r);
    logic [7:0]  b;
    logic        eos;
    logic [1:0]  n;
    int          sh;
    logic [20:0] cp;
    logic [7:0]  raw;
    b = it.in_byte;
    eos = it.end_of_string;
    r = '0;
    if (dec_drop) begin
      if (eos) begin
        dec_drop = 1'b0;
        dec_acc = '0;
        dec_left = '0;
      end
      return 1'b0;
    end
    if (dec_left == 2'd0) begin
      if (b >= 192) begin
        n = (b >= 240) ? 2'd3 : (b >= 224) ? 2'd2 : 2'd1;
        sh = 6 - n;
        dec_acc = 21'(b) & ((21'd1 << sh) - 21'd1);
        dec_left = n;
        if (eos) begin
          dec_acc = '0;
          dec_left = '0;
          r.status = STATUS_TRUNC;
          r.last = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      dec_acc = 21'(b);
    end else begin
      dec_acc = {dec_acc[14:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left != 2'd0) begin
        if (eos) begin
          dec_acc = '0;
          dec_left = '0;
          r.status = STATUS_TRUNC;
          r.last = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
    end
    cp = dec_acc;
    dec_acc = '0;
    dec_left = '0;
    if (map_code_point(cp, raw)) begin
      r.out_byte = raw;
      r.status = STATUS_OK;
      r.last = eos;
    end else begin
      if (!eos) dec_drop = 1'b1;
      r.status = STATUS_UNSUP;
      r.last = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic push_byte(input in_item_t it, input byte_note_t nt);
    while ($urandom_range(99) < gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    byte_notes = {byte_notes, nt};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic send_random_string();
    in_item_t    str_q[$];
    in_item_t    it;
    byte_note_t  nt;
    logic [20:0] cp;
    logic [7:0]  enc [4];
    int          kind;
    int          ncp;
    int          nb;
    int          keep;
    int          i;
    int          j;
    nt = '0;
    kind = $urandom_range(99);
    if (kind < 12) begin
      ncp = $urandom_range(1, 8);
      for (i = 0; i < ncp; i++) begin
        it.in_byte = 8'($urandom);
        it.end_of_string = 1'b0;
        str_q = {str_q, it};
      end
    end else begin
      ncp = $urandom_range(1, 6);
      for (i = 0; i < ncp; i++) begin
        if (kind < 24 && $urandom_range(3) == 0) begin
          case ($urandom_range(4))
            0: cp = 21'($urandom_range(32));
            1: cp = 21'($urandom_range(127, 160));
            2: cp = 21'd173;
            3: cp = 21'($urandom_range(324, 2047));
            default: cp = 21'($urandom_range(2048, 21'h1FFFFF));
          endcase
        end else begin
          case ($urandom_range(3))
            0: cp = 21'($urandom_range(33, 126));
            1: begin
              cp = 21'($urandom_range(161, 255));
              if (cp == 21'd173) cp = 21'd174;
            end
            default: cp = 21'($urandom_range(256, 323));
          endcase
        end
        if (cp < 128 || (cp < 192 && $urandom_range(3) == 0)) begin
          nb = 1;
        end else begin
          nb = (cp < 2048) ? 2 : (cp < 65536) ? 3 : 4;
        end
        if (nb < 4 && $urandom_range(9) == 0) nb = $urandom_range(nb + 1, 4);
        case (nb)
          1: enc[0] = cp[7:0];
          2: enc[0] = {3'b110, cp[10:6]};
          3: enc[0] = {4'b1110, cp[15:12]};
          default: enc[0] = {4'b1111, 1'($urandom_range(3) == 0), cp[20:18]};
        endcase
        for (j = 1; j < nb; j++) begin
          enc[j] = {($urandom_range(3) == 0) ? 2'($urandom) : 2'b10, cp[6 * (nb - 1 - j) +: 6]};
        end
        keep = nb;
        if (kind >= 24 && kind < 36 && i == ncp - 1 && nb > 1) keep = $urandom_range(1, nb - 1);
        for (j = 0; j < keep; j++) begin
          it.in_byte = enc[j];
          it.end_of_string = 1'b0;
          str_q = {str_q, it};
        end
      end
    end
    str_q[str_q.size() - 1].end_of_string = 1'b1;
    foreach (str_q[k]) push_byte(str_q[k], nt);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      cur_note = byte_notes.pop_front();
      if (!dec_drop) decoded_cnt++;
      got_res = decode_byte(byte_item, pred_res);
      if (cur_note.given) begin
        if (cur_note.has_res) decoded_q = {decoded_q, cur_note.res};
      end else if (got_res) begin
        decoded_q = {decoded_q, pred_res};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: byte=%0d status=%0d last=%0d",
                   res_item.out_byte, res_item.status, res_item.last);
        end
      end else begin
        want = decoded_q.pop_front();
        if (res_item.out_byte !== want.out_byte || res_item.status !== want.status ||
            res_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch: expected byte=%0d status=%0d last=%0d,",
                      " got byte=%0d status=%0d last=%0d"},
                     want.out_byte, want.status, want.last,
                     res_item.out_byte, res_item.status, res_item.last);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_item_t   it;
    byte_note_t nt;
    int         ph;
    int         target;
    dir_rows = '{
      '{8'h21, 1'b0, 1'b1, 1'b1, 8'h21, STATUS_OK,    1'b0},
      '{8'h7E, 1'b1, 1'b1, 1'b1, 8'h7E, STATUS_OK,    1'b1},
      '{8'h20, 1'b0, 1'b1, 1'b1, 8'h00, STATUS_UNSUP, 1'b1},
      '{8'h41, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hC4, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hC5, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h83, 1'b0, 1'b0, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hC4, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hA1, 1'b1, 1'b0, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h80, 1'b0, 1'b1, 1'b1, 8'h00, STATUS_UNSUP, 1'b1},
      '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hAE, 1'b0, 1'b1, 1'b1, 8'hAE, STATUS_OK,    1'b0},
      '{8'hAD, 1'b1, 1'b1, 1'b1, 8'h00, STATUS_UNSUP, 1'b1},
      '{8'hC3, 1'b1, 1'b1, 1'b1, 8'h00, STATUS_TRUNC, 1'b1},
      '{8'hE0, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b1, 8'h00, STATUS_TRUNC, 1'b1},
      '{8'hF7, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hBF, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hBF, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hBF, 1'b1, 1'b0, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'hF0, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h80, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h84, 1'b0, 1'b1, 1'b0, 8'h00, STATUS_OK,    1'b0},
      '{8'h40, 1'b1, 1'b0, 1'b0, 8'h00, STATUS_OK,    1'b0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 20;
    stall_pct = 59;
    foreach (dir_rows[r]) begin
      it.in_byte = dir_rows[r].b;
      it.end_of_string = dir_rows[r].eos;
      nt.given = dir_rows[r].given;
      nt.has_res = dir_rows[r].has_res;
      nt.res.out_byte = dir_rows[r].exp_byte;
      nt.res.status = dir_rows[r].exp_status;
      nt.res.last = dir_rows[r].exp_last;
      push_byte(it, nt);
    end
    for (ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 20 : (ph == 1) ? 59 : 0;
      stall_pct = (ph == 0) ? 59 : (ph == 1) ? 20 : 0;
      target = decoded_cnt + 370;
      while (decoded_cnt < target) send_random_string();
    end
    byte_valid <= 1'b0;
    while (decoded_q.size() != 0 || byte_notes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
